[sv/lsbw_pkg.sv]
// Types and constants shared by the logit stick-breaking weights block.
package lsbw_pkg;

  typedef enum logic [2:0] {
    CMD_SAMPLE = 3'd0,
    CMD_ICPT   = 3'd1,
    CMD_SLOPE  = 3'd2,
    CMD_CENTER = 3'd3,
    CMD_GRID   = 3'd4
  } cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_S_RD,
    ST_S_GRD,
    ST_S_MUL,
    ST_S_ACC,
    ST_L_RD,
    ST_L_T,
    ST_L_Y2,
    ST_L_Y3,
    ST_L_Y4,
    ST_L_E,
    ST_L_E2,
    ST_L_SQ,
    ST_L_SQW,
    ST_L_DIV,
    ST_DIV,
    ST_L_W,
    ST_L_W2,
    ST_L_R,
    ST_N_RD,
    ST_N_DIV,
    ST_N_OUT
  } state_e;

  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [61:0] HALF_Q30 = 62'h2000_0000;
  localparam logic [19:0] RECIP6   = 20'd699051;
  localparam logic [15:0] RECIP24  = 16'd43691;
  localparam int          NUMW     = 61;
  localparam int          SQUARES  = 8;

endpackage

[sv/logit_stick_breaking_weights_top.sv]
// Logit stick-breaking mixture weights: table memories, score update and weight sequencer.
//
// A transaction is taken when start_i is high and busy_o is low. Table writes
// (intercept, slope, center index, grid value) complete in the accepting cycle
// and leave busy_o low. A feature sample updates every component score in turn
// with a read, grid lookup, multiply and saturating accumulate, during which
// busy_o is high. A sample marked last then runs the logistic and stick-breaking
// pass per component, using a bit-serial divider and the shared 31 x 31
// multiplier for the series, its eight squarings and the stick-breaking products.
// A normalising pass through the same divider follows. Each weight appears on
// the result ports for one cycle with weight_valid_o high, in component order,
// last_weight_o marking the final one. The receiver cannot stall; results are
// never held back or repeated. Reset clears the sequencer and marks every
// score as zero; the tables hold nothing defined until written.
module logit_stick_breaking_weights_top #(
  parameter int COMPONENTS  = 16,
  parameter int FEATURES    = 8,
  parameter int GRID_POINTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  command_i,
  input  logic [3:0]  component_i,
  input  logic [2:0]  feature_i,
  input  logic [3:0]  grid_slot_i,
  input  logic signed [15:0] value_i,
  input  logic        last_feature_i,
  output logic        weight_valid_o,
  output logic [3:0]  component_out_o,
  output logic [15:0] weight_o,
  output logic        last_weight_o
);
  import lsbw_pkg::*;

  localparam int CW  = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
  localparam int SAW = (COMPONENTS * FEATURES > 1) ? $clog2(COMPONENTS * FEATURES) : 1;
  localparam int GAW = $clog2(FEATURES * GRID_POINTS);
  localparam int GIW = $clog2(GRID_POINTS);
  localparam int DW  = 31 + CW;

  state_e state_q, state_d;
  logic [CW-1:0] h_q, h_d;
  logic [5:0] cnt_q, cnt_d;
  logic norm_q, norm_d;
  logic [COMPONENTS-1:0] sv_q;
  logic accept, h_last;

  logic [15:0] icpt_mem [COMPONENTS];
  logic [15:0] slope_mem [COMPONENTS*FEATURES];
  logic [GIW-1:0] ctr_mem [COMPONENTS*FEATURES];
  logic [15:0] grid_mem [FEATURES*GRID_POINTS];
  logic [31:0] score_mem [COMPONENTS];
  logic [30:0] w_mem [COMPONENTS];

  logic [15:0] icpt_rd_q, slope_rd_q, grid_rd_q;
  logic [GIW-1:0] ctr_rd_q;
  logic [31:0] score_rd_q;
  logic [30:0] w_rd_q;
  logic [SAW-1:0] sa;
  logic [GAW-1:0] ga;
  logic [GIW-1:0] ctr_wr;

  logic [2:0] feat_q;
  logic signed [15:0] val_q;
  logic last_q;
  logic signed [15:0] slope_q;
  logic signed [31:0] base_q;
  logic signed [33:0] prod_s_q;
  logic signed [16:0] diff;
  logic [16:0] mag_d;
  logic signed [33:0] term, s_wide;
  logic [31:0] s_sat;

  logic [31:0] sc;
  logic signed [32:0] sc_ext;
  logic [32:0] sc_mag;
  logic [16:0] t_cap;
  logic neg_q;
  logic [30:0] y_q, y2_q, y3_q, e_q, v_q, rem_q;
  logic [17:0] q6_q;
  logic [11:0] q24_q;
  logic [19:0] x6;
  logic [39:0] p6;
  logic [15:0] x24;
  logic [31:0] p24;
  logic [31:0] e_sum;
  logic [30:0] mul_a, mul_b, mq;
  logic [61:0] prod_q;
  logic [DW-1:0] sum_q;

  logic [NUMW-1:0] dnum_q;
  logic [DW-1:0] dden_q, drem_q;
  logic [31:0] dq_q;
  logic [DW:0] dsh;
  logic dge;
  logic [31:0] den_l;

  logic weight_valid_q, last_weight_q;
  logic [3:0] comp_out_q;
  logic [15:0] weight_q;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);
  assign h_last = (int'(h_q) == COMPONENTS - 1);

  assign sa = SAW'(int'(h_q) * FEATURES + int'(feat_q));
  assign ga = GAW'(int'(feat_q) * GRID_POINTS + int'(ctr_rd_q));
  assign ctr_wr = (int'(value_i[7:0]) >= GRID_POINTS) ? GIW'(GRID_POINTS - 1)
                                                      : GIW'(value_i[7:0]);

  always_ff @(posedge clk_i) begin
    if (accept && (command_i == CMD_ICPT) && (int'(component_i) < COMPONENTS)) begin
      icpt_mem[CW'(component_i)] <= value_i;
    end
    if (accept && (command_i == CMD_SLOPE) && (int'(component_i) < COMPONENTS) &&
        (int'(feature_i) < FEATURES)) begin
      slope_mem[SAW'(int'(component_i) * FEATURES + int'(feature_i))] <= value_i;
    end
    if (accept && (command_i == CMD_CENTER) && (int'(component_i) < COMPONENTS) &&
        (int'(feature_i) < FEATURES)) begin
      ctr_mem[SAW'(int'(component_i) * FEATURES + int'(feature_i))] <= ctr_wr;
    end
    if (accept && (command_i == CMD_GRID) && (int'(feature_i) < FEATURES) &&
        (int'(grid_slot_i) < GRID_POINTS)) begin
      grid_mem[GAW'(int'(feature_i) * GRID_POINTS + int'(grid_slot_i))] <= value_i;
    end
    if (state_q == ST_S_ACC) begin
      score_mem[h_q] <= s_sat;
    end
    if (state_q == ST_L_W2) begin
      w_mem[h_q] <= mq;
    end
    icpt_rd_q  <= icpt_mem[h_q];
    slope_rd_q <= slope_mem[sa];
    ctr_rd_q   <= ctr_mem[sa];
    grid_rd_q  <= grid_mem[ga];
    score_rd_q <= score_mem[h_q];
    w_rd_q     <= w_mem[h_q];
  end

  // Score update arithmetic.
  always_comb begin
    diff   = 17'(val_q) - 17'($signed(grid_rd_q));
    mag_d  = diff[16] ? 17'(-diff) : 17'(diff);
    term   = (prod_s_q + 34'sd2048) >>> 12;
    s_wide = 34'(base_q) - term;
    if (s_wide > 34'sh0_7FFF_FFFF) begin
      s_sat = 32'h7FFF_FFFF;
    end else if (s_wide < -34'sh0_8000_0000) begin
      s_sat = 32'h8000_0000;
    end else begin
      s_sat = s_wide[31:0];
    end
  end

  // Logistic series, shared multiplier and divider step.
  always_comb begin
    sc     = sv_q[h_q] ? score_rd_q : '0;
    sc_ext = {sc[31], sc};
    sc_mag = sc[31] ? 33'(-sc_ext) : 33'(sc_ext);
    t_cap  = (sc_mag > 33'd65536) ? 17'd65536 : sc_mag[16:0];
    x6     = 20'(y3_q) + 20'd3;
    p6     = 40'(x6) * 40'(RECIP6);
    x24    = 16'(mq) + 16'd12;
    p24    = 32'(x24) * 32'(RECIP24);
    e_sum  = 32'(ONE_Q30) - 32'(y_q) + ((32'(y2_q) + 32'd1) >> 1) - 32'(q6_q) + 32'(q24_q);
    mq     = 31'((prod_q + HALF_Q30) >> 30);
    den_l  = 32'(ONE_Q30) + 32'(e_q);
    dsh    = {drem_q, dnum_q[NUMW-1]};
    dge    = (dsh >= {1'b0, dden_q});
    mul_a  = y_q;
    mul_b  = y_q;
    case (state_q)
      ST_L_Y3, ST_L_Y4: begin
        mul_a = mq;
        mul_b = y_q;
      end
      ST_L_SQ: begin
        mul_a = e_q;
        mul_b = e_q;
      end
      ST_L_W: begin
        mul_a = dq_q[30:0];
        mul_b = rem_q;
      end
      ST_L_W2: begin
        mul_a = rem_q;
        mul_b = ONE_Q30 - v_q;
      end
      default: begin
        mul_a = y_q;
        mul_b = y_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 62'(mul_a) * 62'(mul_b);
    if (accept) begin
      feat_q <= feature_i;
      val_q  <= value_i;
      last_q <= last_feature_i;
    end
    case (state_q)
      ST_IDLE: begin
        rem_q <= ONE_Q30;
        sum_q <= '0;
      end
      ST_S_GRD: begin
        slope_q <= slope_rd_q;
        base_q  <= (feat_q == 3'd0) ? 32'($signed(icpt_rd_q)) : (sv_q[h_q] ? score_rd_q : '0);
      end
      ST_S_MUL: prod_s_q <= 34'(slope_q) * 34'($signed({1'b0, mag_d}));
      ST_L_T: begin
        y_q   <= 31'({t_cap, 10'b0});
        neg_q <= sc[31];
      end
      ST_L_Y3: y2_q <= mq;
      ST_L_Y4: y3_q <= mq;
      ST_L_E: begin
        q6_q  <= p6[39:22];
        q24_q <= p24[31:20];
      end
      ST_L_E2: e_q <= 31'(e_sum);
      ST_L_SQW: e_q <= mq;
      ST_L_DIV: begin
        dden_q <= DW'(den_l);
        drem_q <= '0;
        dnum_q <= (neg_q ? {e_q, 30'b0} : NUMW'({ONE_Q30, 30'b0})) + NUMW'(den_l >> 1);
      end
      ST_DIV: begin
        drem_q <= dge ? DW'(dsh - {1'b0, dden_q}) : DW'(dsh);
        dq_q   <= {dq_q[30:0], dge};
        dnum_q <= dnum_q << 1;
      end
      ST_L_W: v_q <= dq_q[30:0];
      ST_L_W2: sum_q <= sum_q + DW'(mq);
      ST_L_R: rem_q <= mq;
      ST_N_DIV: begin
        dden_q <= sum_q;
        drem_q <= '0;
        dq_q   <= '0;
        dnum_q <= NUMW'({w_rd_q, 16'b0}) + NUMW'(sum_q >> 1);
      end
      ST_N_OUT: begin
        comp_out_q    <= 4'(h_q);
        weight_q      <= (dq_q > 32'd65535) ? 16'hFFFF : dq_q[15:0];
        last_weight_q <= h_last;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    h_d     = h_q;
    cnt_d   = cnt_q;
    norm_d  = norm_q;
    unique case (state_q)
      ST_IDLE: begin
        norm_d = 1'b0;
        h_d    = '0;
        if (accept && (command_i == CMD_SAMPLE)) begin
          if (int'(feature_i) < FEATURES) begin
            state_d = ST_S_RD;
          end else if (last_feature_i) begin
            state_d = ST_L_RD;
          end
        end
      end
      ST_S_RD:  state_d = ST_S_GRD;
      ST_S_GRD: state_d = ST_S_MUL;
      ST_S_MUL: state_d = ST_S_ACC;
      ST_S_ACC: begin
        if (!h_last) begin
          h_d     = h_q + 1'b1;
          state_d = ST_S_RD;
        end else begin
          h_d     = '0;
          state_d = last_q ? ST_L_RD : ST_IDLE;
        end
      end
      ST_L_RD: state_d = ST_L_T;
      ST_L_T:  state_d = ST_L_Y2;
      ST_L_Y2: state_d = ST_L_Y3;
      ST_L_Y3: state_d = ST_L_Y4;
      ST_L_Y4: state_d = ST_L_E;
      ST_L_E:  state_d = ST_L_E2;
      ST_L_E2: begin
        cnt_d   = '0;
        state_d = ST_L_SQ;
      end
      ST_L_SQ: state_d = ST_L_SQW;
      ST_L_SQW: begin
        cnt_d   = cnt_q + 1'b1;
        state_d = (int'(cnt_q) == SQUARES - 1) ? ST_L_DIV : ST_L_SQ;
      end
      ST_L_DIV: begin
        cnt_d   = 6'(NUMW - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = norm_q ? ST_N_OUT : ST_L_W;
        end
      end
      ST_L_W:  state_d = ST_L_W2;
      ST_L_W2: state_d = ST_L_R;
      ST_L_R: begin
        if (!h_last) begin
          h_d     = h_q + 1'b1;
          state_d = ST_L_RD;
        end else begin
          h_d     = '0;
          norm_d  = 1'b1;
          state_d = ST_N_RD;
        end
      end
      ST_N_RD: state_d = ST_N_DIV;
      ST_N_DIV: begin
        cnt_d   = 6'(NUMW - 1);
        state_d = (sum_q == '0) ? ST_N_OUT : ST_DIV;
      end
      ST_N_OUT: begin
        if (!h_last) begin
          h_d     = h_q + 1'b1;
          state_d = ST_N_RD;
        end else begin
          h_d     = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      h_q            <= '0;
      cnt_q          <= '0;
      norm_q         <= 1'b0;
      sv_q           <= '0;
      weight_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      h_q            <= h_d;
      cnt_q          <= cnt_d;
      norm_q         <= norm_d;
      weight_valid_q <= (state_q == ST_N_OUT);
      if (state_q == ST_S_ACC) begin
        sv_q[h_q] <= 1'b1;
      end
    end
  end

  assign weight_valid_o  = weight_valid_q;
  assign component_out_o = comp_out_q;
  assign weight_o        = weight_q;
  assign last_weight_o   = last_weight_q;

endmodule

[tb/logit_stick_breaking_weights_top_tb.sv]
// Self-checking testbench for the logit stick-breaking weights block.
module logit_stick_breaking_weights_top_tb;
  import lsbw_pkg::*;

  typedef struct {
    cmd_e        cmd;
    logic [3:0]  comp;
    logic [2:0]  feat;
    logic [3:0]  slot;
    logic [15:0] value;
    logic        last;
    logic        drain;
  } txn_t;

  typedef struct {
    logic [3:0]  comp;
    logic [15:0] weight;
    logic        last;
  } weight_t;

  localparam int NCOMP = 16;
  localparam int NFEAT = 8;
  localparam int NGRID = 16;
  localparam int SFEAT = 2;
  localparam logic [63:0] ONE30 = 64'd1 << 30;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [2:0]  command_i = CMD_SAMPLE;
  logic [3:0]  component_i = '0;
  logic [2:0]  feature_i = '0;
  logic [3:0]  grid_slot_i = '0;
  logic signed [15:0] value_i = '0;
  logic        last_feature_i = 1'b0;
  logic        weight_valid_o;
  logic [3:0]  component_out_o;
  logic [15:0] weight_o;
  logic        last_weight_o;

  logit_stick_breaking_weights_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  txn_t    pending_txns[$];
  weight_t expected_weights[$];
  logic [15:0] icpt_tab[NCOMP];
  logic [15:0] slope_tab[NCOMP*NFEAT];
  logic [7:0]  centre_tab[NCOMP*NFEAT];
  logic [15:0] grid_tab[NFEAT*NGRID];
  logic signed [31:0] score_tab[NCOMP];
  int errors = 0;
  int weights_seen = 0;
  int samples_sent = 0;
  int burst_left = 0;
  int gap_left = 0;

  function automatic logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] logistic_q30(logic signed [31:0] score);
    longint s;
    logic [63:0] t, y, y2, y3, y4, e, den;
    s = score;
    t = (s < 0) ? -s : s;
    if (t > 64'd65536) t = 64'd65536;
    y = t << 10;
    y2 = mul_q30(y, y);
    y3 = mul_q30(y2, y);
    y4 = mul_q30(y3, y);
    e = ONE30 - y + (y2 + 1) / 2 - (y3 + 3) / 6 + (y4 + 12) / 24;
    for (int i = 0; i < 8; i++) e = mul_q30(e, e);
    den = ONE30 + e;
    if (score >= 0) return ((ONE30 << 30) + den / 2) / den;
    return ((e << 30) + den / 2) / den;
  endfunction

  function automatic longint round_q12(longint p);
    longint q;
    q = p + 2048;
    if (q >= 0) return q / 4096;
    return -((-q + 4095) / 4096);
  endfunction

  task automatic predict_weights(txn_t t);
    logic [63:0] w[NCOMP];
    logic [63:0] rem, sum, v, wt;
    longint g, d, s;
    int idx, c;
    weight_t r;
    case (t.cmd)
      CMD_ICPT: icpt_tab[t.comp] = t.value;
      CMD_SLOPE: slope_tab[t.comp*NFEAT+t.feat] = t.value;
      CMD_CENTER: centre_tab[t.comp*NFEAT+t.feat] = t.value[7:0];
      CMD_GRID: grid_tab[t.feat*NGRID+t.slot] = t.value;
      CMD_SAMPLE: begin
        for (int h = 0; h < NCOMP; h++) begin
          idx = h * NFEAT + t.feat;
          c = (centre_tab[idx] >= NGRID) ? NGRID - 1 : centre_tab[idx];
          if (t.feat == 0) score_tab[h] = $signed(icpt_tab[h]);
          g = $signed(grid_tab[t.feat*NGRID+c]);
          d = longint'($signed(t.value)) - g;
          if (d < 0) d = -d;
          s = longint'(score_tab[h]) - round_q12(longint'($signed(slope_tab[idx])) * d);
          if (s > 64'sd2147483647) s = 64'sd2147483647;
          if (s < -64'sd2147483648) s = -64'sd2147483648;
          score_tab[h] = s[31:0];
        end
        if (t.last) begin
          rem = ONE30;
          sum = 0;
          for (int h = 0; h < NCOMP; h++) begin
            v = logistic_q30(score_tab[h]);
            w[h] = mul_q30(v, rem);
            rem = mul_q30(rem, ONE30 - v);
            sum += w[h];
          end
          for (int h = 0; h < NCOMP; h++) begin
            wt = 0;
            if (sum > 0) begin
              wt = ((w[h] << 16) + sum / 2) / sum;
              if (wt > 64'd65535) wt = 64'd65535;
            end
            r.comp = h[3:0];
            r.weight = wt[15:0];
            r.last = (h == NCOMP - 1);
            expected_weights.insert(expected_weights.size(), r);
          end
        end
      end
      default: ;
    endcase
  endtask

  txn_t cur_txn;
  logic accepted;
  logic drain_ok;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      accepted = start_i && !busy_o;
      if (accepted) begin
        predict_weights(cur_txn);
        if (cur_txn.cmd == CMD_SAMPLE && cur_txn.last) samples_sent++;
      end
      if (start_i && !accepted) begin
      end else begin
        drain_ok = (pending_txns.size() != 0) &&
                   (!pending_txns[0].drain ||
                    (!accepted && !busy_o && expected_weights.size() == 0));
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
        if (gap_left == 0 && drain_ok) begin
          cur_txn = pending_txns.pop_front();
          command_i <= cur_txn.cmd;
          component_i <= cur_txn.comp;
          feature_i <= cur_txn.feat;
          grid_slot_i <= cur_txn.slot;
          value_i <= cur_txn.value;
          last_feature_i <= cur_txn.last;
          start_i <= 1'b1;
          burst_left--;
        end else begin
          start_i <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    weight_t exp_w;
    if (rst_ni && weight_valid_o) begin
      weights_seen++;
      if (expected_weights.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected weight: comp %0d weight %0d last %0b",
                                   component_out_o, weight_o, last_weight_o);
      end else begin
        exp_w = expected_weights.pop_front();
        if (exp_w.comp !== component_out_o || exp_w.weight !== weight_o ||
            exp_w.last !== last_weight_o) begin
          errors++;
          if (errors <= 10)
            $display("Weight error: expected comp %0d weight %0d last %0b, got %0d %0d %0b",
                     exp_w.comp, exp_w.weight, exp_w.last,
                     component_out_o, weight_o, last_weight_o);
        end
      end
    end
  end

  task automatic add_txn(cmd_e cmd, int comp, int feat, int slot, logic [15:0] value,
                         bit last, bit drain = 0);
    txn_t t;
    t.cmd = cmd;
    t.comp = comp[3:0];
    t.feat = feat[2:0];
    t.slot = slot[3:0];
    t.value = value;
    t.last = last;
    t.drain = drain;
    pending_txns.insert(pending_txns.size(), t);
  endtask

  task automatic add_sample(bit extreme);
    logic [15:0] v;
    for (int f = 0; f < SFEAT; f++) begin
      v = extreme ? (($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000)
                  : 16'($urandom_range(0, 16383) - 8192);
      add_txn(CMD_SAMPLE, $urandom_range(0, 15), f, $urandom_range(0, 15), v,
              f == SFEAT - 1);
    end
  endtask

  initial begin
    for (int c = 0; c < NCOMP; c++)
      add_txn(CMD_ICPT, c, 0, 0, 16'($urandom_range(0, 32767) - 16384), 0);
    for (int c = 0; c < NCOMP; c++)
      for (int f = 0; f < SFEAT; f++) begin
        add_txn(CMD_SLOPE, c, f, 0, 16'($urandom_range(0, 2047) - 512), 0);
        add_txn(CMD_CENTER, c, f, 0, 16'($urandom_range(0, 65535)), 0);
      end
    for (int f = 0; f < SFEAT; f++)
      for (int g = 0; g < NGRID; g++)
        add_txn(CMD_GRID, 0, f, g, 16'($urandom_range(0, 65535)), 0);

    add_sample(0);
    add_txn(CMD_ICPT, 0, 0, 0, 16'h7FFF, 1);
    add_txn(CMD_ICPT, 15, 0, 0, 16'h8000, 0);
    add_txn(CMD_SLOPE, 1, 1, 0, 16'h7FFF, 0);
    add_txn(CMD_SLOPE, 2, 1, 0, 16'h8000, 0);
    add_txn(CMD_CENTER, 3, 1, 0, 16'hFFFF, 1);
    add_txn(CMD_GRID, 0, 1, 15, 16'h8000, 0);
    add_txn(cmd_e'(3'd5), 1, 1, 1, 16'h1234, 1);
    add_txn(cmd_e'(3'd6), 2, 2, 2, 16'hFFFF, 0);
    add_txn(cmd_e'(3'd7), 15, 7, 15, 16'h0000, 1);
    add_sample(1);
    add_txn(CMD_SAMPLE, 0, 1, 0, 16'h0100, 0);
    add_txn(CMD_SAMPLE, 0, SFEAT - 1, 0, 16'hF000, 1, 1);

    while (pending_txns.size() < 210) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          case ($urandom_range(1, 4))
            1: add_txn(CMD_ICPT, $urandom_range(0, 15), 0, 0, 16'($urandom), $urandom_range(0, 1));
            2: add_txn(CMD_SLOPE, $urandom_range(0, 15), $urandom_range(0, 7), 0,
                       16'($urandom), $urandom_range(0, 1));
            3: add_txn(CMD_CENTER, $urandom_range(0, 15), $urandom_range(0, 7), 0,
                       16'($urandom), 0);
            default: add_txn(CMD_GRID, 0, $urandom_range(0, 7), $urandom_range(0, 15),
                             16'($urandom), 0);
          endcase
        end
        2: add_txn(CMD_SAMPLE, $urandom_range(0, 15), $urandom_range(0, SFEAT - 1),
                   $urandom_range(0, 15), 16'($urandom), $urandom_range(0, 3) == 0);
        3: add_txn(cmd_e'(3'($urandom_range(5, 7))), $urandom_range(0, 15),
                   $urandom_range(0, 7), $urandom_range(0, 15), 16'($urandom), 1);
        default: add_sample($urandom_range(0, 5) == 0);
      endcase
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_txns.size() == 0 && !start_i);
    wait (expected_weights.size() == 0 && !busy_o);
    repeat (300) @(posedge clk_i);
    $display("Covered table writes, ignored commands and %0d completed samples;",
             samples_sent);
    $display("%0d weights checked.", weights_seen);
    if (errors == 0 && expected_weights.size() == 0) begin
      $display("logit_stick_breaking_weights_top: match");
    end else begin
      $display("%0d mismatches counted.", errors);
      $display("logit_stick_breaking_weights_top: mismatch");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Run timed out.");
    $display("logit_stick_breaking_weights_top: mismatch");
    $finish;
  end

endmodule
